// ===== sv/lhtc_pkg.sv =====
// ----------------------------------------------------------------------------
// lhtc_pkg
// Shared types and constants for the LRU handle tag cache.
// ----------------------------------------------------------------------------
package lhtc_pkg;

    localparam int KEY_W   = 32;
    localparam int STAMP_W = 64;
    localparam int SLOT_W  = 4;
    localparam int FCNT_W  = 5;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
    } scan_ctrl_t;

    typedef struct packed {
        logic found;
        logic have_empty;
        logic have_old;
    } scan_flags_t;

endpackage

// ===== sv/lhtc_ram.sv =====
// ----------------------------------------------------------------------------
// lhtc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lhtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lhtc_scan.sv =====
// ----------------------------------------------------------------------------
// lhtc_scan
// Per-slot scan unit: tag match, first empty slot, oldest stamp, valid count.
// ----------------------------------------------------------------------------
module lhtc_scan #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lhtc_pkg::scan_ctrl_t               ctrl,
    input  logic [lhtc_pkg::KEY_W-1:0]         key,
    input  logic                               ent_valid,
    input  logic [$clog2(NUM_SLOTS)-1:0]       ent_idx,
    input  logic [lhtc_pkg::KEY_W-1:0]         ent_tag,
    input  logic [lhtc_pkg::STAMP_W-1:0]       ent_stamp,
    output lhtc_pkg::scan_flags_t              flags,
    output logic [$clog2(NUM_SLOTS)-1:0]       match_idx,
    output logic [$clog2(NUM_SLOTS)-1:0]       empty_idx,
    output logic [$clog2(NUM_SLOTS)-1:0]       old_idx,
    output logic [lhtc_pkg::KEY_W-1:0]         old_tag,
    output logic [$clog2(NUM_SLOTS+1)-1:0]     valid_cnt
);
    import lhtc_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    scan_flags_t        flags_reg, flags_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]   old_idx_reg, old_idx_next;
    logic [KEY_W-1:0]   old_tag_reg, old_tag_next;
    logic [STAMP_W-1:0] old_stamp_reg, old_stamp_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               is_match;
    logic               is_older;

    assign is_match = (ent_tag == key);
    assign is_older = (ent_stamp < old_stamp_reg);

    always_comb
    begin
        flags_next     = flags_reg;
        match_idx_next = match_idx_reg;
        empty_idx_next = empty_idx_reg;
        old_idx_next   = old_idx_reg;
        old_tag_next   = old_tag_reg;
        old_stamp_next = old_stamp_reg;
        cnt_next       = cnt_reg;
        if (ctrl.clear)
        begin
            flags_next = '0;
            cnt_next   = '0;
        end
        else if (ctrl.load)
        begin
            if (ent_valid)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (!flags_reg.found && is_match)
                begin
                    flags_next.found = 1'b1;
                    match_idx_next   = ent_idx;
                end
                if (!flags_reg.have_old || is_older)
                begin
                    flags_next.have_old = 1'b1;
                    old_idx_next        = ent_idx;
                    old_tag_next        = ent_tag;
                    old_stamp_next      = ent_stamp;
                end
            end
            else if (!flags_reg.have_empty)
            begin
                flags_next.have_empty = 1'b1;
                empty_idx_next        = ent_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        empty_idx_reg <= empty_idx_next;
        old_idx_reg   <= old_idx_next;
        old_tag_reg   <= old_tag_next;
        old_stamp_reg <= old_stamp_next;
    end

    assign flags     = flags_reg;
    assign match_idx = match_idx_reg;
    assign empty_idx = empty_idx_reg;
    assign old_idx   = old_idx_reg;
    assign old_tag   = old_tag_reg;
    assign valid_cnt = cnt_reg;

endmodule

// ===== sv/lru_handle_tag_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_handle_tag_cache_top
// Each transfer is scanned one slot per cycle through the tag and stamp RAM
// read ports; the result and the write-back are issued in ST_FINISH once the
// output can take it, and a new transfer is accepted only back in ST_IDLE, so
// no item is taken before the previous one is through.
// Reset: all slots invalid and use counter zero at once; no clearing pass.
// ----------------------------------------------------------------------------
module lru_handle_tag_cache_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [lhtc_pkg::KEY_W-1:0]    key_id,
    input  logic                          open_ok,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [lhtc_pkg::SLOT_W-1:0]   slot,
    output logic                          granted,
    output logic                          evicted,
    output logic [lhtc_pkg::KEY_W-1:0]    evicted_id,
    output logic [lhtc_pkg::FCNT_W-1:0]   flushed_count
);
    import lhtc_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               proc_v_reg, proc_v_next;
    logic [IDX_W-1:0]   proc_idx_reg, proc_idx_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [STAMP_W-1:0] counter_reg, counter_next;
    logic               act_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               open_reg;

    logic               out_valid_reg, out_valid_next;
    logic               hit_reg, hit_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               granted_reg, granted_next;
    logic               evicted_reg, evicted_next;
    logic [KEY_W-1:0]   evicted_id_reg, evicted_id_next;
    logic [FCNT_W-1:0]  fcnt_reg, fcnt_next;

    logic               accept;
    logic               issue;
    logic               fire;
    scan_ctrl_t         scan_ctrl;
    scan_flags_t        flags;
    logic [IDX_W-1:0]   match_idx;
    logic [IDX_W-1:0]   empty_idx;
    logic [IDX_W-1:0]   old_idx;
    logic [IDX_W-1:0]   pick_idx;
    logic [IDX_W-1:0]   wr_idx;
    logic [KEY_W-1:0]   old_tag;
    logic [CNT_W-1:0]   valid_cnt;
    logic [KEY_W-1:0]   tag_rdata;
    logic [STAMP_W-1:0] stamp_rdata;
    logic               tag_we;
    logic               stamp_we;
    logic               is_lookup;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(NUM_SLOTS))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready        = 1'b0;
        issue           = 1'b0;
        fire            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                issue = (cnt_reg < CNT_W'(NUM_SLOTS));
            end
            ST_FINISH:
            begin
                fire = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept          = in_valid && in_ready;
    assign scan_ctrl.clear = accept;
    assign scan_ctrl.load  = proc_v_reg;
    assign is_lookup       = (act_reg == ACT_LOOKUP);

    assign pick_idx = flags.have_empty ? empty_idx : old_idx;
    assign wr_idx   = flags.found ? match_idx : pick_idx;
    assign tag_we   = fire && is_lookup && !flags.found && open_reg;
    assign stamp_we = fire && is_lookup && (flags.found || open_reg);

    lhtc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (NUM_SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (wr_idx),
        .wdata (key_reg),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (tag_rdata)
    );

    lhtc_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (NUM_SLOTS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (wr_idx),
        .wdata (counter_reg),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (stamp_rdata)
    );

    lhtc_scan #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .key       (key_reg),
        .ent_valid (valid_reg[proc_idx_reg]),
        .ent_idx   (proc_idx_reg),
        .ent_tag   (tag_rdata),
        .ent_stamp (stamp_rdata),
        .flags     (flags),
        .match_idx (match_idx),
        .empty_idx (empty_idx),
        .old_idx   (old_idx),
        .old_tag   (old_tag),
        .valid_cnt (valid_cnt)
    );

    always_comb
    begin
        cnt_next      = cnt_reg;
        proc_v_next   = issue;
        proc_idx_next = cnt_reg[IDX_W-1:0];
        counter_next  = counter_reg;
        if (accept)
        begin
            cnt_next = '0;
            if (action == ACT_LOOKUP)
            begin
                counter_next = counter_reg + STAMP_W'(1);
            end
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // write-back and result
    always_comb
    begin
        valid_next      = valid_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        granted_next    = granted_reg;
        evicted_next    = evicted_reg;
        evicted_id_next = evicted_id_reg;
        fcnt_next       = fcnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (fire)
        begin
            out_valid_next  = 1'b1;
            hit_next        = 1'b0;
            slot_next       = '0;
            granted_next    = 1'b0;
            evicted_next    = 1'b0;
            evicted_id_next = '0;
            fcnt_next       = '0;
            if (!is_lookup)
            begin
                valid_next = '0;
                fcnt_next  = FCNT_W'(valid_cnt);
            end
            else if (flags.found)
            begin
                hit_next     = 1'b1;
                granted_next = 1'b1;
                slot_next    = SLOT_W'(match_idx);
            end
            else
            begin
                slot_next            = SLOT_W'(pick_idx);
                granted_next         = open_reg;
                valid_next[pick_idx] = open_reg;
                if (!flags.have_empty)
                begin
                    evicted_next    = 1'b1;
                    evicted_id_next = old_tag;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            proc_v_reg    <= 1'b0;
            valid_reg     <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            proc_v_reg    <= proc_v_next;
            valid_reg     <= valid_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg   <= proc_idx_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        granted_reg    <= granted_next;
        evicted_reg    <= evicted_next;
        evicted_id_reg <= evicted_id_next;
        fcnt_reg       <= fcnt_next;
        if (accept)
        begin
            act_reg  <= action;
            key_reg  <= key_id;
            open_reg <= open_ok;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign granted       = granted_reg;
    assign evicted       = evicted_reg;
    assign evicted_id    = evicted_id_reg;
    assign flushed_count = fcnt_reg;

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit reported together with eviction");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !is_lookup) |=> (valid_reg == '0))
        else $error("valid bits remain after flush");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_W'(NUM_SLOTS)))
        else $error("scan index out of range");

    a_fill_needs_open: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_lookup && !flags.found && !open_reg) |=> !granted)
        else $error("grant on failed open");

endmodule
